>>> rtl/acdam_pkg.sv
// acdam_pkg: shared types and constants of the double-array Aho-Corasick matcher
// used by the channel interfaces and the matcher top level; no dependencies
`default_nettype none

package acdam_pkg;

	// default sizing of the trie store and the alphabet
	localparam int TABLE_DEPTH_DEF = 1024;
	localparam int ALPHABET_DEF    = 26;

	// fixed field widths of the channels
	localparam int IDX_W   = 10;
	localparam int CHECK_W = 11;
	localparam int SYM_W   = 5;
	localparam int TOTAL_W = 32;

	// item commands
	localparam logic CMD_WRITE  = 1'b0;
	localparam logic CMD_SYMBOL = 1'b1;

	// node numbering
	localparam int ROOT_NODE = 1;
	localparam int MATCH_MAX = 1023;

	// one trie entry as kept in the store
	typedef struct packed {
		logic [IDX_W-1:0]          base;
		logic signed [CHECK_W-1:0] check;
		logic [IDX_W-1:0]          fail;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

endpackage

`default_nettype wire

>>> rtl/acdam_in_if.sv
// acdam_in_if: input channel of the matcher (table writes and text symbols)
// depends on acdam_pkg for field widths
`default_nettype none

interface acdam_in_if
	import acdam_pkg::*;
();
	logic                      valid;
	logic                      ready;
	logic                      cmd;
	logic [IDX_W-1:0]          entry_index;
	logic [IDX_W-1:0]          entry_base;
	logic signed [CHECK_W-1:0] entry_check;
	logic [IDX_W-1:0]          entry_fail;
	logic [SYM_W-1:0]          symbol;
	logic                      text_start;

	modport source (
		output valid, cmd, entry_index, entry_base, entry_check, entry_fail,
		       symbol, text_start,
		input  ready
	);

	modport sink (
		input  valid, cmd, entry_index, entry_base, entry_check, entry_fail,
		       symbol, text_start,
		output ready
	);
endinterface

`default_nettype wire

>>> rtl/acdam_out_if.sv
// acdam_out_if: result channel of the matcher
// depends on acdam_pkg for field widths
`default_nettype none

interface acdam_out_if
	import acdam_pkg::*;
();
	logic               valid;
	logic               ready;
	logic [IDX_W-1:0]   matches_here;
	logic [TOTAL_W-1:0] match_total;
	logic [IDX_W-1:0]   node_now;

	modport source (
		output valid, matches_here, match_total, node_now,
		input  ready
	);

	modport sink (
		input  valid, matches_here, match_total, node_now,
		output ready
	);
endinterface

`default_nettype wire

>>> rtl/acdam_ram.sv
// acdam_ram: generic single-port RAM with registered read data
// no dependencies
`default_nettype none

module acdam_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port and registered read of the same address
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata_q <= mem[addr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

>>> rtl/aho_corasick_double_array_matcher.sv
// aho_corasick_double_array_matcher: top level, sequencer and datapath of the matcher
// depends on acdam_pkg, acdam_in_if, acdam_out_if and acdam_ram
`default_nettype none

// Multi-pattern match counter over a double-array trie held in one single-port
// RAM of TABLE_DEPTH entries (base, signed check, fail link). After reset the
// block clears the check field of every entry, one entry per cycle, and
// accepts no item until the clear is done. A table write item is stored as it
// is accepted. A text symbol is accepted in ST_IDLE, then runs ST_FRD, ST_FSLOT
// and ST_FCMP for every node tried on the fail walk (read the node, read the
// child slot, compare) and ST_CRD and ST_CACC for every node visited while
// counting word ends along the output chain; both walks share the single RAM
// port. Each walk stops after at most TABLE_DEPTH nodes. One result per item
// is held in an output register; while it waits there no new item is taken,
// except in the cycle in which that result leaves.
module aho_corasick_double_array_matcher
	import acdam_pkg::*;
#(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
	parameter int ALPHABET    = ALPHABET_DEF
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	acdam_in_if.sink    req,
	acdam_out_if.source rsp
);

	localparam int IW = $clog2(TABLE_DEPTH);
	localparam int SW = IW + 1;

	typedef enum logic [6:0] {
		ST_CLEAR = 7'b0000001,
		ST_IDLE  = 7'b0000010,
		ST_FRD   = 7'b0000100,
		ST_FSLOT = 7'b0001000,
		ST_FCMP  = 7'b0010000,
		ST_CRD   = 7'b0100000,
		ST_CACC  = 7'b1000000
	} state_t;

	// reduce an index or a base plus symbol sum below TABLE_DEPTH
	function automatic logic [IW-1:0] wrap_idx(input logic [10:0] v);
		logic [31:0] r;
		r = 32'(v);
		for (int k = 4; k >= 0; k--) begin
			if (r >= (32'(TABLE_DEPTH) << k)) begin
				r = r - (32'(TABLE_DEPTH) << k);
			end
		end
		return r[IW-1:0];
	endfunction

	state_t             state_q;
	logic [IW-1:0]      clr_q;
	logic [IW-1:0]      node_q;
	logic [TOTAL_W-1:0] total_q;
	logic [IW-1:0]      p_q;
	logic [IW-1:0]      slot_q;
	logic [IDX_W-1:0]   fail_q;
	logic [SYM_W-1:0]   sym_q;
	logic [SW-1:0]      steps_q;
	logic [SW-1:0]      cnt_q;
	logic               ovalid_q;
	logic [IDX_W-1:0]   omatch_q;
	logic [TOTAL_W-1:0] ototal_q;
	logic [IDX_W-1:0]   onode_q;

	logic               ram_we;
	logic [IW-1:0]      ram_addr;
	logic [ENTRY_W-1:0] ram_wdata;
	logic [ENTRY_W-1:0] ram_rdata;
	entry_t             rd;

	logic               accept;
	logic [IW-1:0]      p_start;
	logic [TOTAL_W-1:0] total_start;
	logic [IW-1:0]      slot_next;
	logic [CHECK_W-1:0] check_mag;
	logic               hit;
	logic [IW-1:0]      p_fail;
	logic [IW-1:0]      q_fail;
	logic [SW-1:0]      steps_inc;
	logic [SW-1:0]      cnt_inc;

	// finishing an item: result register, node and total update
	logic               fin_en;
	logic [IW-1:0]      fin_node;
	logic [SW-1:0]      fin_cnt;
	logic [TOTAL_W-1:0] fin_base;
	logic [TOTAL_W:0]   fin_sum;
	logic [TOTAL_W-1:0] fin_total;
	logic [IDX_W-1:0]   fin_match;
	state_t             state_d;

	acdam_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (TABLE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	assign rd        = entry_t'(ram_rdata);
	assign req.ready = (state_q == ST_IDLE) && (!ovalid_q || rsp.ready);
	assign accept    = req.valid && req.ready;

	// start point of a symbol, after an optional restart
	assign p_start     = req.text_start ? IW'(ROOT_NODE) : node_q;
	assign total_start = req.text_start ? '0 : total_q;

	// child lookup and link following
	assign slot_next = wrap_idx(11'(rd.base) + 11'(sym_q));
	assign check_mag = rd.check[CHECK_W-1] ? CHECK_W'(-rd.check) : CHECK_W'(rd.check);
	assign hit       = (32'(check_mag) == 32'(p_q));
	assign p_fail    = wrap_idx(11'(fail_q));
	assign q_fail    = wrap_idx(11'(rd.fail));
	assign steps_inc = steps_q + SW'(1);
	assign cnt_inc   = cnt_q + SW'(rd.check[CHECK_W-1]);

	// store port selection
	always_comb begin
		ram_we    = 1'b0;
		ram_addr  = p_q;
		ram_wdata = '0;
		case (state_q)
			ST_CLEAR: begin
				ram_we   = 1'b1;
				ram_addr = clr_q;
			end
			ST_IDLE: begin
				ram_addr  = wrap_idx(11'(req.entry_index));
				ram_wdata = entry_t'{
					base:  req.entry_base,
					check: req.entry_check,
					fail:  req.entry_fail
				};
				ram_we    = accept && (req.cmd == CMD_WRITE);
			end
			ST_FRD:   ram_addr = p_q;
			ST_FSLOT: ram_addr = slot_next;
			ST_CRD:   ram_addr = slot_q;
			default:  ram_addr = p_q;
		endcase
	end

	// sequencer decisions
	always_comb begin
		state_d  = state_q;
		fin_en   = 1'b0;
		fin_node = node_q;
		fin_cnt  = '0;
		fin_base = total_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_q == IW'(TABLE_DEPTH - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					if (req.cmd == CMD_WRITE) begin
						fin_en = 1'b1;
					end else begin
						fin_base = total_start;
						if ((32'(req.symbol) >= 32'(ALPHABET)) || (p_start == '0)) begin
							fin_en   = 1'b1;
							fin_node = IW'(ROOT_NODE);
						end else begin
							state_d = ST_FRD;
						end
					end
				end
			end
			ST_FRD:   state_d = ST_FSLOT;
			ST_FSLOT: state_d = ST_FCMP;
			ST_FCMP: begin
				if (hit) begin
					if (slot_q == '0) begin
						fin_en   = 1'b1;
						fin_node = slot_q;
						state_d  = ST_IDLE;
					end else begin
						state_d = ST_CRD;
					end
				end else if ((p_fail == '0) || (steps_inc == SW'(TABLE_DEPTH))) begin
					fin_en   = 1'b1;
					fin_node = IW'(ROOT_NODE);
					state_d  = ST_IDLE;
				end else begin
					state_d = ST_FRD;
				end
			end
			ST_CRD: state_d = ST_CACC;
			ST_CACC: begin
				if ((q_fail == '0) || (steps_inc == SW'(TABLE_DEPTH))) begin
					fin_en  = 1'b1;
					fin_cnt = cnt_inc;
					state_d = ST_IDLE;
				end else begin
					state_d = ST_CRD;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// saturating totals of the finished item
	assign fin_sum   = (TOTAL_W+1)'(fin_base) + (TOTAL_W+1)'(fin_cnt);
	assign fin_total = fin_sum[TOTAL_W] ? '1 : fin_sum[TOTAL_W-1:0];
	assign fin_match = (32'(fin_cnt) > 32'(MATCH_MAX)) ? IDX_W'(MATCH_MAX) : IDX_W'(fin_cnt);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			clr_q    <= '0;
			node_q   <= IW'(ROOT_NODE);
			total_q  <= '0;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + IW'(1);
			end
			if (fin_en) begin
				node_q   <= fin_node;
				total_q  <= fin_total;
				ovalid_q <= 1'b1;
			end else begin
				if (state_q == ST_FCMP && hit) begin
					node_q <= slot_q;
				end
				if (accept && req.cmd == CMD_SYMBOL) begin
					total_q <= total_start;
				end
				if (rsp.ready) begin
					ovalid_q <= 1'b0;
				end
			end
		end
	end

	// walk registers and result payload
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				p_q     <= p_start;
				sym_q   <= req.symbol;
				steps_q <= '0;
			end
			ST_FSLOT: begin
				fail_q <= rd.fail;
				slot_q <= slot_next;
			end
			ST_FCMP: begin
				if (hit) begin
					steps_q <= '0;
					cnt_q   <= '0;
				end else begin
					p_q     <= p_fail;
					steps_q <= steps_inc;
				end
			end
			ST_CACC: begin
				slot_q  <= q_fail;
				steps_q <= steps_inc;
				cnt_q   <= cnt_inc;
			end
			default: begin
			end
		endcase
		if (fin_en) begin
			omatch_q <= fin_match;
			ototal_q <= fin_total;
			onode_q  <= IDX_W'(fin_node);
		end
	end

	assign rsp.valid        = ovalid_q;
	assign rsp.matches_here = omatch_q;
	assign rsp.match_total  = ototal_q;
	assign rsp.node_now     = onode_q;

endmodule

`default_nettype wire
